// ===== hw/rtl/co2lc_pkg.sv =====
// Shared widths, constants, types and the root table of the CO2 converter.
package co2lc_pkg;

  // Field and accumulator widths
  localparam int SAMPLE_W = 10;
  localparam int REF_W    = 10;
  localparam int SUM_W    = 15;
  localparam int PPM_W    = 20;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_HIGH = 1'b1;

  // Divider: dividend is |delta| * 2^18 + divisor/2, quotient kept to 22 bits
  localparam int DVD_W   = 33;
  localparam int DVS_W   = 16;
  localparam int QUO_W   = 22;
  localparam int SHIFT_Q = 18;

  // Exponent and base-2 product
  localparam int X_W  = 22;
  localparam int XW_W = 25;
  localparam int QS_W = 24;
  localparam int P_W  = 40;
  localparam int L2_W = 18;
  localparam int N_W  = 8;
  localparam int FRAC_W = 16;

  localparam logic signed [XW_W-1:0] LOG10_400_Q16 = 25'sd170529;
  localparam logic [L2_W-1:0]        LOG2_10_Q16   = 18'd217706;
  localparam logic signed [XW_W-1:0] X_MIN = -25'sd2097152;
  localparam logic signed [XW_W-1:0] X_MAX = 25'sd2097151;
  localparam logic [P_W-1:0]         P_ROUND = 40'd32768;
  localparam logic [QUO_W:0]         QM_SAT  = 23'h400000;

  // Mantissa multiply: Q30 mantissa times table entry, one byte of the entry a cycle
  localparam int M_W   = 31;
  localparam int DIG_W = 8;
  localparam int N_DIG = 4;
  localparam int T_W   = DIG_W * N_DIG;
  localparam int HI_W  = 32;
  localparam int LO_W  = DIG_W * N_DIG;
  localparam logic [M_W-1:0] M_ONE = 31'h40000000;

  localparam logic [PPM_W-1:0] PPM_MAX = 20'hFFFFF;

  // Range limits of the base-2 integer part
  localparam logic signed [N_W-1:0] N_SAT  = 8'sd20;
  localparam logic signed [N_W-1:0] N_ZERO = -8'sd10;
  localparam logic signed [N_W-1:0] N_BIAS = 8'sd29;

  // Divider status
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  // round(2^(2^-(i+1)) * 2^30)
  function automatic logic [M_W-1:0] root_val(input logic [3:0] i);
    logic [M_W-1:0] r;
    unique case (i)
      4'd0:  r = 31'd1518500250;
      4'd1:  r = 31'd1276901417;
      4'd2:  r = 31'd1170923762;
      4'd3:  r = 31'd1121280438;
      4'd4:  r = 31'd1097253708;
      4'd5:  r = 31'd1085434106;
      4'd6:  r = 31'd1079572136;
      4'd7:  r = 31'd1076653033;
      4'd8:  r = 31'd1075196444;
      4'd9:  r = 31'd1074468888;
      4'd10: r = 31'd1074105294;
      4'd11: r = 31'd1073923544;
      4'd12: r = 31'd1073832680;
      4'd13: r = 31'd1073787251;
      4'd14: r = 31'd1073764537;
      4'd15: r = 31'd1073753181;
      default: r = M_ONE;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/co2_two_point_log_converter_top.sv =====
// Top level of the two-point logarithmic CO2 converter.
// Samples are summed in groups of SAMPLES; the last sample of a group starts a
// conversion to ppm, which goes from that sample to the result word through
// the prepare and start states, the bit-serial divider (33 steps and the done
// flag), loading the exponent, shift-and-add for the base-2 exponent,
// classifying the range, the mantissa (16 table roots, each multiplied one byte
// a cycle, then committed when its fraction bit is set), then a serial right
// shift and a rounding step. A result that saturates or rounds to zero is ready
// once the range is classified, without the mantissa steps.
// Sample words are taken one per cycle inside a group;
// no sample is taken while a conversion runs, nor the last sample of a group
// while the previous result still waits. Equal references give a result at
// once, with bad_reference set and ppm zero. Configuration writes are taken
// every cycle.
module co2_two_point_log_converter_top #(
  parameter int SAMPLES = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [co2lc_pkg::SAMPLE_W-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [co2lc_pkg::PPM_W-1:0]    ppm,
  output logic                           saturated,
  output logic                           bad_reference,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [co2lc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [co2lc_pkg::REF_W-1:0]    cfg_data
);
  import co2lc_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);
  localparam logic [SUM_W-1:0] SAMPLES_S = SUM_W'(SAMPLES);

  localparam logic [3:0] ST_ACC   = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_START = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_EXP   = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_CLS   = 4'd6;
  localparam logic [3:0] ST_POW   = 4'd7;
  localparam logic [3:0] ST_SHF   = 4'd8;
  localparam logic [3:0] ST_RND   = 4'd9;

  localparam logic [4:0] MUL_LAST = 5'(L2_W - 1);
  localparam logic [2:0] DIG_COMMIT = 3'(N_DIG);

  logic [3:0]         state;
  logic [CNT_W-1:0]   count;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   cv_sum;
  logic [REF_W-1:0]   ref_low_co2;
  logic [REF_W-1:0]   ref_high_co2;

  logic [DVD_W-1:0]   dvd_in;
  logic [DVS_W-1:0]   dvs_in;
  logic               neg;
  logic               div_start;
  div_stat_t          div_stat;
  logic [QUO_W-1:0]   div_q;

  logic signed [QS_W-1:0] qs;
  logic [P_W-1:0]     xs;
  logic [P_W-1:0]     p;
  logic [L2_W-1:0]    ksr;
  logic [4:0]         kcnt;

  logic [M_W-1:0]     m;
  logic [HI_W-1:0]    hi;
  logic [LO_W-1:0]    lo;
  logic [T_W-1:0]     tsr;
  logic [FRAC_W-1:0]  fbits;
  logic [3:0]         tab_i;
  logic [2:0]         dig;
  logic [5:0]         shf_cnt;
  logic [M_W-1:0]     vsr;

  logic               in_accept;
  logic               last;
  logic [SUM_W-1:0]   sum_next;
  logic [SUM_W-1:0]   srl;
  logic signed [SUM_W:0] dlt;
  logic [SUM_W-1:0]   dabs;
  logic signed [REF_W:0] rdif;
  logic [REF_W-1:0]   rabs;
  logic [SUM_W-1:0]   ad;
  logic [QUO_W:0]     qm;
  logic signed [XW_W-1:0] xw;
  logic signed [X_W-1:0]  x_cl;
  logic signed [N_W-1:0]  n;
  logic signed [N_W-1:0]  sh;
  logic [DIG_W+M_W-1:0]   prod;
  logic [P_W-1:0]     t;
  logic [M_W-1:0]     m_next;
  logic [M_W:0]       vr;
  logic [M_W-1:0]     v;

  assign cfg_ready = 1'b1;
  assign last      = (count == LAST_CNT);
  assign in_ready  = (state == ST_ACC) && !(out_valid && last);
  assign in_accept = in_valid && in_ready;
  assign sum_next  = sum + SUM_W'(sample);

  // Form divider operands from the group sum and the references
  always_comb begin
    srl  = SUM_W'(SAMPLES_S * SUM_W'(ref_low_co2));
    dlt  = $signed({1'b0, cv_sum}) - $signed({1'b0, srl});
    dabs = dlt[SUM_W] ? SUM_W'(-dlt) : dlt[SUM_W-1:0];
    rdif = $signed({1'b0, ref_low_co2}) - $signed({1'b0, ref_high_co2});
    rabs = rdif[REF_W] ? REF_W'(-rdif) : rdif[REF_W-1:0];
    ad   = SUM_W'(SAMPLES_S * SUM_W'(rabs));
  end

  // Saturate the quotient magnitude and clamp the exponent
  always_comb begin
    qm = div_stat.ovf ? QM_SAT : {1'b0, div_q};
    xw = LOG10_400_Q16 - XW_W'(qs);
    if (xw < X_MIN) begin
      x_cl = X_W'(X_MIN);
    end else if (xw > X_MAX) begin
      x_cl = X_W'(X_MAX);
    end else begin
      x_cl = xw[X_W-1:0];
    end
  end

  // Split the base-2 exponent and multiply the mantissa by one byte
  always_comb begin
    n      = $signed(p[P_W-1:P_W-N_W]);
    sh     = N_BIAS - n;
    prod   = m * tsr[DIG_W-1:0];
    t      = {{(P_W-HI_W){1'b0}}, hi} + {{(P_W-DIG_W-M_W){1'b0}}, prod};
    m_next = {hi[M_W-3:0], lo[LO_W-1:LO_W-2]} + M_W'(lo[LO_W-3]);
    vr     = {1'b0, vsr} + (M_W+1)'(1);
    v      = vr[M_W:1];
  end

  co2lc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_in),
    .divisor  (dvs_in),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Control: references, accumulation, sequencer, output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ACC;
      count        <= '0;
      sum          <= '0;
      ref_low_co2  <= '0;
      ref_high_co2 <= '0;
      out_valid    <= 1'b0;
      div_start    <= 1'b0;
    end else begin
      div_start <= 1'b0;

      // Hold the references
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_REF_LOW:  ref_low_co2  <= cfg_data;
          REG_REF_HIGH: ref_high_co2 <= cfg_data;
          default: ;
        endcase
      end

      // Drop the output word once taken
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_ACC: begin
          if (in_accept) begin
            if (last) begin
              sum   <= '0;
              count <= '0;
              if (ref_low_co2 == ref_high_co2) begin
                out_valid <= 1'b1;
              end else begin
                state <= ST_PREP;
              end
            end else begin
              sum   <= sum_next;
              count <= count + 1'b1;
            end
          end
        end
        ST_PREP: begin
          div_start <= 1'b1;
          state     <= ST_START;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_EXP;
          end
        end
        ST_EXP: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (kcnt == MUL_LAST) begin
            state <= ST_CLS;
          end
        end
        ST_CLS: begin
          if (n >= N_SAT || n < N_ZERO) begin
            out_valid <= 1'b1;
            state     <= ST_ACC;
          end else begin
            state <= ST_POW;
          end
        end
        ST_POW: begin
          if (dig == DIG_COMMIT && tab_i == 4'd15) begin
            state <= ST_SHF;
          end
        end
        ST_SHF: begin
          if (shf_cnt == '0) begin
            state <= ST_RND;
          end
        end
        ST_RND: begin
          out_valid <= 1'b1;
          state     <= ST_ACC;
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_ACC: begin
        if (in_accept && last) begin
          cv_sum        <= sum_next;
          ppm           <= '0;
          saturated     <= 1'b0;
          bad_reference <= (ref_low_co2 == ref_high_co2);
        end
      end
      ST_PREP: begin
        dvd_in <= {dabs, {SHIFT_Q{1'b0}}} + DVD_W'(ad);
        dvs_in <= {ad, 1'b0};
        neg    <= (dlt[SUM_W] != rdif[REF_W]) && (dlt != '0);
      end
      ST_DIV: begin
        qs <= neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      end
      ST_EXP: begin
        xs   <= P_W'(x_cl);
        p    <= P_ROUND;
        ksr  <= LOG2_10_Q16;
        kcnt <= '0;
      end
      ST_MUL: begin
        // Add the shifted exponent for each set constant bit
        if (ksr[0]) begin
          p <= p + xs;
        end
        xs   <= {xs[P_W-2:0], 1'b0};
        ksr  <= ksr >> 1;
        kcnt <= kcnt + 1'b1;
      end
      ST_CLS: begin
        if (n >= N_SAT) begin
          ppm       <= PPM_MAX;
          saturated <= 1'b1;
        end
        m       <= M_ONE;
        hi      <= '0;
        tsr     <= T_W'(root_val(4'd0));
        fbits   <= p[P_W-N_W-1:P_W-N_W-FRAC_W];
        tab_i   <= '0;
        dig     <= '0;
        shf_cnt <= sh[5:0];
      end
      ST_POW: begin
        if (dig == DIG_COMMIT) begin
          // Commit the rounded product when this root's fraction bit is set
          if (fbits[FRAC_W-1]) begin
            m   <= m_next;
            vsr <= m_next;
          end else begin
            vsr <= m;
          end
          fbits <= {fbits[FRAC_W-2:0], 1'b0};
          hi    <= '0;
          tsr   <= T_W'(root_val(tab_i + 1'b1));
          tab_i <= tab_i + 1'b1;
          dig   <= '0;
        end else begin
          hi  <= t[P_W-1:DIG_W];
          lo  <= {t[DIG_W-1:0], lo[LO_W-1:DIG_W]};
          tsr <= tsr >> DIG_W;
          dig <= dig + 1'b1;
        end
      end
      ST_SHF: begin
        if (shf_cnt != '0) begin
          vsr     <= vsr >> 1;
          shf_cnt <= shf_cnt - 1'b1;
        end
      end
      ST_RND: begin
        if (v > M_W'(PPM_MAX)) begin
          ppm       <= PPM_MAX;
          saturated <= 1'b1;
        end else begin
          ppm <= v[PPM_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/co2lc_div.sv =====
// Bit-serial restoring divider with a flag for quotients of 2^22 and above.
module co2lc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [co2lc_pkg::DVD_W-1:0] dividend,
  input  logic [co2lc_pkg::DVS_W-1:0] divisor,
  output co2lc_pkg::div_stat_t        stat,
  output logic [co2lc_pkg::QUO_W-1:0] quotient
);
  import co2lc_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic              ovf;

  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  // Bring down one dividend bit and try the subtraction
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift dividend, remainder and quotient; catch bits above the kept quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
      ovf      <= 1'b0;
    end else if (busy) begin
      dvd      <= {dvd[DVD_W-2:0], 1'b0};
      rem      <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quotient <= {quotient[QUO_W-2:0], ge};
      ovf      <= ovf | quotient[QUO_W-1];
    end
  end

  assign stat.done = done;
  assign stat.ovf  = ovf;

endmodule
